[sv/pid_position_controller_assert.svh]
// assertion macros shared by the controller checks
`ifndef PID_POSITION_CONTROLLER_ASSERT_SVH
`define PID_POSITION_CONTROLLER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define PPC_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ppc check failed");

// next-cycle implication, disabled while in reset
`define PPC_ASSERT_NXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ppc check failed");

`endif

[sv/ppc_pkg.sv]
// package for the pid position controller: field widths, register indexes, scaling constants
package ppc_pkg;

    localparam int TARGET_W   = 16;
    localparam int POS_W      = 12;
    localparam int CMD_W      = 16;
    localparam int ERR_OUT_W  = 13;
    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 15;

    localparam int OUT_W      = CMD_W + POS_W + ERR_OUT_W;
    localparam int M_DATA_W   = ((OUT_W + 7) / 8) * 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LOW_LIMIT     = 3'd0,
        CFG_HIGH_LIMIT    = 3'd1,
        CFG_P_GAIN        = 3'd2,
        CFG_I_GAIN        = 3'd3,
        CFG_D_GAIN        = 3'd4,
        CFG_COMMAND_LIMIT = 3'd5
    } cfg_index_t;

    localparam logic [POS_W-1:0] LOW_LIMIT_RST  = '0;
    localparam logic [POS_W-1:0] HIGH_LIMIT_RST = '1;

    // proportional term is /1024, integral term is /2048
    localparam int P_SHIFT = 10;
    localparam int I_SHIFT = 11;

    // integrator magnitude stays within 2048 * limit
    localparam int INT_W = LIM_W + I_SHIFT + 1;

    // derivative /40 done as /8 then /5 by reciprocal multiply
    localparam int D_PRE_SHIFT   = 3;
    localparam int D_MAG_W       = 21;
    localparam int D_OCT_W       = D_MAG_W - D_PRE_SHIFT;
    localparam int D_RECIP_W     = 16;
    localparam int D_RECIP_SHIFT = 18;
    localparam logic [D_RECIP_W-1:0] D_RECIP = 16'd52429;
    // 40 * 32768: any magnitude at or above this saturates at every limit
    localparam logic [D_MAG_W-1:0] D_SAT = 21'd1310720;

endpackage

[sv/pid_position_controller.sv]
// pid position controller: target clamp, error, p/i/d terms and output clamp
//
// s_ channel carries one control tick per transaction: target position and feedback sample.
// m_ channel returns drive command, clamped target and position error per transaction.
// cfg_ channel writes limits and gains by register index; it is always ready and should only
// be used while no transaction is in flight. Unknown indexes are dropped.
// Pipeline: input register, product register, output register. One transaction per cycle is
// sustained unless a result is stalled; the three gain multiplies sit in the first
// stage, the divides, integrator and clamps in the second. The integrator and last error
// each feed back through a single register, so the rate is 1 per cycle when not stalled.
// When m_tready is low with a result waiting, the whole pipeline holds and s_tready drops;
// it rises again in the cycle the result is taken.
// Reset (aresetn low, synchronous) empties the pipeline, clears the integrator and last
// error, and restores limits 0..4095 with all gains and the command limit at zero.
module pid_position_controller #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // target_position [15:0], feedback_sample [16 +: SAMPLE_BITS], zero pad
    input  logic [((16 + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // drive_command [15:0], clamped_target [27:16], position_error [40:28], zero pad
    output logic [ppc_pkg::M_DATA_W-1:0]         m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ppc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ppc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import ppc_pkg::*;

    localparam int ERR_W = ((SAMPLE_BITS > POS_W) ? SAMPLE_BITS : POS_W) + 1;
    localparam int PP_W  = ERR_W + GAIN_W + 1;
    localparam int DP_W  = ERR_W + GAIN_W + 2;
    localparam int PT_W  = PP_W - P_SHIFT;
    localparam int ACC_W = ((PP_W > INT_W) ? PP_W : INT_W) + 1;
    localparam int SUM_W = PT_W + 2;

    // configuration registers
    logic [POS_W-1:0]  low_limit_reg;
    logic [POS_W-1:0]  high_limit_reg;
    logic [GAIN_W-1:0] p_gain_reg;
    logic [GAIN_W-1:0] i_gain_reg;
    logic [GAIN_W-1:0] d_gain_reg;
    logic [LIM_W-1:0]  command_limit_reg;

    // pipeline control
    logic in_valid_reg;
    logic prod_valid_reg;
    logic out_valid_reg;
    logic advance;

    // stage 0: input register
    logic [TARGET_W-1:0]    target_reg;
    logic [SAMPLE_BITS-1:0] feedback_reg;

    // stage 1: products
    logic [POS_W-1:0]       clamped_next;
    logic signed [ERR_W-1:0] err_next;
    logic signed [ERR_W:0]  diff_next;
    logic signed [PP_W-1:0] p_prod_next;
    logic signed [PP_W-1:0] i_prod_next;
    logic signed [DP_W-1:0] d_prod_next;

    logic [POS_W-1:0]        clamped_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [PP_W-1:0]  p_prod_reg;
    logic signed [PP_W-1:0]  i_prod_reg;
    logic signed [DP_W-1:0]  d_prod_reg;

    // loop state
    logic signed [ERR_W-1:0] last_error_reg;
    logic signed [INT_W-1:0] integral_reg;
    logic signed [INT_W-1:0] integral_next;

    // stage 2 signals
    logic signed [PP_W-1:0]  p_biased;
    logic signed [PT_W-1:0]  p_term;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [ACC_W-1:0] acc_lim;
    logic signed [ACC_W-1:0] acc_clamped;
    logic signed [INT_W-1:0] i_biased;
    logic signed [CMD_W-1:0] i_term;
    logic                    d_neg;
    logic [DP_W-1:0]         d_mag;
    logic                    d_big;
    logic [D_OCT_W-1:0]      d_oct;
    logic [D_OCT_W+D_RECIP_W-1:0] d_quot_full;
    logic [CMD_W-1:0]        d_quot;
    logic [LIM_W-1:0]        d_mag_clamped;
    logic signed [CMD_W-1:0] d_term;
    logic signed [SUM_W-1:0] sum_raw;
    logic signed [SUM_W-1:0] sum_lim;
    logic signed [SUM_W-1:0] sum_clamped;
    logic signed [CMD_W-1:0] drive_next;

    // output register
    logic signed [CMD_W-1:0]     drive_reg;
    logic [POS_W-1:0]            out_target_reg;
    logic signed [ERR_OUT_W-1:0] out_error_reg;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = advance;
    assign m_tvalid  = out_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_tdata   = {{(M_DATA_W - OUT_W){1'b0}}, out_error_reg, out_target_reg, drive_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_limit_reg     <= LOW_LIMIT_RST;
            high_limit_reg    <= HIGH_LIMIT_RST;
            p_gain_reg        <= '0;
            i_gain_reg        <= '0;
            d_gain_reg        <= '0;
            command_limit_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LOW_LIMIT:     low_limit_reg     <= cfg_data[POS_W-1:0];
                CFG_HIGH_LIMIT:    high_limit_reg    <= cfg_data[POS_W-1:0];
                CFG_P_GAIN:        p_gain_reg        <= cfg_data[GAIN_W-1:0];
                CFG_I_GAIN:        i_gain_reg        <= cfg_data[GAIN_W-1:0];
                CFG_D_GAIN:        d_gain_reg        <= cfg_data[GAIN_W-1:0];
                CFG_COMMAND_LIMIT: command_limit_reg <= cfg_data[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_error_reg <= '0;
            integral_reg   <= '0;
        end else if (advance) begin
            in_valid_reg   <= s_tvalid;
            prod_valid_reg <= in_valid_reg;
            out_valid_reg  <= prod_valid_reg;
            if (in_valid_reg) begin
                last_error_reg <= err_next;
            end
            if (prod_valid_reg) begin
                integral_reg <= integral_next;
            end
        end
    end

    // payload registers move with the pipeline, no reset needed
    always_ff @(posedge aclk) begin
        if (advance) begin
            target_reg     <= s_tdata[TARGET_W-1:0];
            feedback_reg   <= s_tdata[TARGET_W +: SAMPLE_BITS];
            clamped_reg    <= clamped_next;
            err_reg        <= err_next;
            p_prod_reg     <= p_prod_next;
            i_prod_reg     <= i_prod_next;
            d_prod_reg     <= d_prod_next;
            drive_reg      <= drive_next;
            out_target_reg <= clamped_reg;
            out_error_reg  <= err_reg[ERR_OUT_W-1:0];
        end
    end

    // stage 1: clamp target, form error and difference, three gain products
    always_comb begin
        if (target_reg > {{(TARGET_W - POS_W){1'b0}}, high_limit_reg}) begin
            clamped_next = high_limit_reg;
        end else if (target_reg < {{(TARGET_W - POS_W){1'b0}}, low_limit_reg}) begin
            clamped_next = low_limit_reg;
        end else begin
            clamped_next = target_reg[POS_W-1:0];
        end
        err_next = $signed({{(ERR_W - SAMPLE_BITS){1'b0}}, feedback_reg})
                 - $signed({{(ERR_W - POS_W){1'b0}}, clamped_next});
        diff_next = $signed({err_next[ERR_W-1], err_next})
                  - $signed({last_error_reg[ERR_W-1], last_error_reg});
        p_prod_next = err_next * $signed({1'b0, p_gain_reg});
        i_prod_next = err_next * $signed({1'b0, i_gain_reg});
        d_prod_next = diff_next * $signed({1'b0, d_gain_reg});
    end

    // stage 2: divides toward zero, integrator clamp, derivative clamp, sum clamp
    always_comb begin
        // bias negative values by divisor - 1 so the shift truncates toward zero
        p_biased = p_prod_reg + $signed({{(PP_W - P_SHIFT){1'b0}},
                                         {P_SHIFT{p_prod_reg[PP_W-1]}}});
        p_term   = p_biased[PP_W-1:P_SHIFT];

        acc_sum = $signed({{(ACC_W - INT_W){integral_reg[INT_W-1]}}, integral_reg})
                + $signed({{(ACC_W - PP_W){i_prod_reg[PP_W-1]}}, i_prod_reg});
        acc_lim = $signed({{(ACC_W - LIM_W - I_SHIFT){1'b0}}, command_limit_reg,
                           {I_SHIFT{1'b0}}});
        if (acc_sum > acc_lim) begin
            acc_clamped = acc_lim;
        end else if (acc_sum < -acc_lim) begin
            acc_clamped = -acc_lim;
        end else begin
            acc_clamped = acc_sum;
        end
        integral_next = acc_clamped[INT_W-1:0];
        i_biased = integral_next + $signed({{(INT_W - I_SHIFT){1'b0}},
                                            {I_SHIFT{integral_next[INT_W-1]}}});
        i_term   = i_biased[INT_W-1:I_SHIFT];

        d_neg = d_prod_reg[DP_W-1];
        d_mag = d_neg ? DP_W'(-d_prod_reg) : DP_W'(d_prod_reg);
        d_big = d_mag >= {{(DP_W - D_MAG_W){1'b0}}, D_SAT};
        d_oct = d_mag[D_MAG_W-1:D_PRE_SHIFT];
        d_quot_full = d_oct * D_RECIP;
        d_quot = d_quot_full[D_RECIP_SHIFT +: CMD_W];
        if (d_big || (d_quot > {1'b0, command_limit_reg})) begin
            d_mag_clamped = command_limit_reg;
        end else begin
            d_mag_clamped = d_quot[LIM_W-1:0];
        end
        d_term = d_neg ? -$signed({1'b0, d_mag_clamped}) : $signed({1'b0, d_mag_clamped});

        sum_raw = $signed({{(SUM_W - PT_W){p_term[PT_W-1]}}, p_term})
                + $signed({{(SUM_W - CMD_W){i_term[CMD_W-1]}}, i_term})
                + $signed({{(SUM_W - CMD_W){d_term[CMD_W-1]}}, d_term});
        sum_lim = $signed({{(SUM_W - LIM_W){1'b0}}, command_limit_reg});
        if (sum_raw > sum_lim) begin
            sum_clamped = sum_lim;
        end else if (sum_raw < -sum_lim) begin
            sum_clamped = -sum_lim;
        end else begin
            sum_clamped = sum_raw;
        end
        drive_next = sum_clamped[CMD_W-1:0];
    end

endmodule

[sv/ppc_checker.sv]
// port-level checks for the pid position controller, bound to the top level
`include "pid_position_controller_assert.svh"

module ppc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ppc_pkg::M_DATA_W-1:0]    m_tdata,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [ppc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [ppc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ppc_pkg::*;

    logic [2:0]       in_flight_reg;
    logic [2:0]       in_flight_next;
    logic [POS_W-1:0] low_reg;
    logic [POS_W-1:0] high_reg;
    logic [POS_W-1:0] out_target;
    logic             in_take;
    logic             out_take;

    assign in_take    = s_tvalid && s_tready;
    assign out_take   = m_tvalid && m_tready;
    assign out_target = m_tdata[CMD_W +: POS_W];

    always_comb begin
        in_flight_next = in_flight_reg;
        if (in_take && !out_take) begin
            in_flight_next = in_flight_reg + 3'd1;
        end else if (out_take && !in_take) begin
            in_flight_next = in_flight_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_flight_reg <= '0;
            low_reg       <= LOW_LIMIT_RST;
            high_reg      <= HIGH_LIMIT_RST;
        end else begin
            in_flight_reg <= in_flight_next;
            if (cfg_valid && cfg_ready && (cfg_index == CFG_LOW_LIMIT)) begin
                low_reg <= cfg_data[POS_W-1:0];
            end
            if (cfg_valid && cfg_ready && (cfg_index == CFG_HIGH_LIMIT)) begin
                high_reg <= cfg_data[POS_W-1:0];
            end
        end
    end

    // a waiting result holds until taken
    `PPC_ASSERT_NXT(a_hold_on_stall, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // input is only held off while a result is stalled
    `PPC_ASSERT_IMP(a_ready_unless_stalled, aclk, aresetn, !(m_tvalid && !m_tready), s_tready)
    // three pipeline stages: never more than three transactions inside, never fewer than zero
    `PPC_ASSERT_IMP(a_in_flight_bound, aclk, aresetn, 1'b1, in_flight_reg <= 3'd3)
    // command never reaches the most negative code; target lands within ordered limits
    `PPC_ASSERT_IMP(a_output_range, aclk, aresetn, m_tvalid, (m_tdata[CMD_W-1:0] != 16'h8000) && ((low_reg > high_reg) || ((out_target >= low_reg) && (out_target <= high_reg))))

endmodule

bind pid_position_controller ppc_checker u_ppc_checker (.*);

[test/tb_pid_position_controller.sv]
`timescale 1ns / 1ps
// testbench for pid_position_controller: directed and random ticks checked against a predictor
module tb_pid_position_controller;
    import ppc_pkg::*;

    localparam int SAMPLE_BITS  = 12;
    localparam int S_DATA_W     = ((16 + SAMPLE_BITS + 7) / 8) * 8;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_TICKS  = 96;
    localparam int NUM_PHASES   = 6;

    // indexes past the register list, writes to them must be dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_B = 3'd7;

    typedef struct packed {
        logic signed [ERR_OUT_W-1:0] err;
        logic [POS_W-1:0]            tgt;
        logic signed [CMD_W-1:0]     cmd;
    } tick_result_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    bit src_gaps_on    = 1'b1;
    bit sink_stalls_on = 1'b1;
    int stall_left     = 0;
    int quiet_cycles   = 0;
    int mismatch_count = 0;

    // predictor copy of the registers and loop state
    longint lo_lim    = 0;
    longint hi_lim    = 4095;
    longint kp        = 0;
    longint ki        = 0;
    longint kd        = 0;
    longint cmd_lim   = 0;
    longint integ_acc = 0;
    longint prev_err  = 0;

    tick_result_t tick_expect_q[$];

    pid_position_controller #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint clamp_mag(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // one control tick: updates the integrator and last error
    function automatic tick_result_t predict_tick(logic [15:0] target,
                                                  logic [SAMPLE_BITS-1:0] fb);
        tick_result_t r;
        longint tgt, fbv, err, lim, pterm, iterm, dterm;
        tgt = longint'(target);
        fbv = longint'(fb);
        lim = cmd_lim;
        if (tgt > hi_lim) tgt = hi_lim;
        else if (tgt < lo_lim) tgt = lo_lim;
        err = fbv - tgt;
        // signed divides truncate toward zero
        pterm = (err * kp) / 1024;
        integ_acc = clamp_mag(integ_acc + err * ki, 2048 * lim);
        iterm = integ_acc / 2048;
        dterm = clamp_mag(((err - prev_err) * kd) / 40, lim);
        prev_err = err;
        r.cmd = CMD_W'(clamp_mag(pterm + iterm + dterm, lim));
        r.tgt = POS_W'(tgt);
        r.err = ERR_OUT_W'(err);
        return r;
    endfunction

    task automatic send_tick(logic [15:0] target, logic [SAMPLE_BITS-1:0] fb);
        if (src_gaps_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({fb, target});
        do @(posedge aclk); while (!s_tready);
        tick_expect_q.push_back(predict_tick(target, fb));
    endtask

    // leaves cfg_valid high so back-to-back writes follow without a gap
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_LOW_LIMIT:     lo_lim  = longint'(data[POS_W-1:0]);
            CFG_HIGH_LIMIT:    hi_lim  = longint'(data[POS_W-1:0]);
            CFG_P_GAIN:        kp      = longint'(data);
            CFG_I_GAIN:        ki      = longint'(data);
            CFG_D_GAIN:        kd      = longint'(data);
            CFG_COMMAND_LIMIT: cmd_lim = longint'(data[LIM_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tick_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_config(logic [15:0] lo, logic [15:0] hi, logic [15:0] p,
                                logic [15:0] i, logic [15:0] d, logic [15:0] lim);
        wait_drained();
        write_reg(CFG_LOW_LIMIT, lo);
        write_reg(CFG_HIGH_LIMIT, hi);
        write_reg(CFG_P_GAIN, p);
        write_reg(CFG_I_GAIN, i);
        write_reg(CFG_D_GAIN, d);
        write_reg(CFG_COMMAND_LIMIT, lim);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return 16'hffff;
            2:       return 16'($urandom_range(0, 2047));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [14:0] pick_limit();
        case ($urandom_range(0, 3))
            0:       return 15'd0;
            1:       return 15'h7fff;
            2:       return 15'($urandom_range(1, 300));
            default: return 15'($urandom_range(0, 32767));
        endcase
    endfunction

    task automatic test_reset_defaults();
        // command limit is zero out of reset, so every command is zero
        send_tick(16'd0, 12'd0);
        send_tick(16'hffff, 12'hfff);
        send_tick(16'd4095, 12'd0);
        send_tick(16'd4096, 12'hfff);
        send_tick(16'd0, 12'hfff);
        wait_drained();
    endtask

    task automatic test_target_clamp();
        apply_config(16'd100, 16'd3000, 16'd1024, 16'd0, 16'd0, 16'h7fff);
        send_tick(16'd50, 12'd200);
        send_tick(16'd100, 12'hfff);
        send_tick(16'd3000, 12'd0);
        send_tick(16'd3001, 12'd2000);
        send_tick(16'hffff, 12'd0);
        // crossed limits: above high gives high, else below low gives low
        apply_config(16'd3000, 16'd100, 16'd1024, 16'd0, 16'd0, 16'h7fff);
        send_tick(16'd4000, 12'd500);
        send_tick(16'd50, 12'd500);
        send_tick(16'd2000, 12'd500);
        send_tick(16'd100, 12'd500);
        wait_drained();
    endtask

    task automatic test_unused_index();
        wait_drained();
        write_reg(CFG_UNUSED_A, 16'hffff);
        write_reg(CFG_UNUSED_B, 16'h0000);
        cfg_valid <= 1'b0;
        send_tick(16'd1000, 12'd1200);
        send_tick(16'd3500, 12'd40);
        wait_drained();
    endtask

    task automatic test_max_gains();
        apply_config(16'd0, 16'd4095, 16'hffff, 16'hffff, 16'hffff, 16'h7fff);
        send_tick(16'd0, 12'hfff);
        send_tick(16'd4095, 12'd0);
        send_tick(16'd0, 12'hfff);
        send_tick(16'd4095, 12'd0);
        send_tick(16'd2048, 12'd2048);
        wait_drained();
    endtask

    task automatic test_lowered_limit();
        apply_config(16'd0, 16'd4095, 16'd0, 16'hffff, 16'd0, 16'h7fff);
        send_tick(16'd0, 12'hfff);
        send_tick(16'd0, 12'hfff);
        // integrator sits at its ceiling, gets reclamped on the next tick
        apply_config(16'd0, 16'd4095, 16'd0, 16'hffff, 16'd0, 16'd5);
        send_tick(16'd2000, 12'd2000);
        // zero limit forces integrator, derivative and command to zero
        apply_config(16'd0, 16'd4095, 16'hffff, 16'hffff, 16'hffff, 16'd0);
        send_tick(16'd0, 12'hfff);
        wait_drained();
    endtask

    task automatic test_random_loop();
        logic [15:0] lo, hi, target;
        int t, fbi;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case ($urandom_range(0, 2))
                0: begin
                    lo = 16'd0;
                    hi = 16'd4095;
                end
                1: begin
                    lo = 16'($urandom_range(0, 2047));
                    hi = 16'($urandom_range(2048, 4095));
                end
                default: begin
                    lo = 16'($urandom_range(0, 4095));
                    hi = 16'($urandom_range(0, 4095));
                end
            endcase
            // stray upper data bits must be ignored by the narrow registers
            lo[15:12] = 4'($urandom_range(0, 15));
            hi[15:12] = 4'($urandom_range(0, 15));
            if (ph == NUM_PHASES - 1) begin
                src_gaps_on    = 1'b0;
                sink_stalls_on = 1'b0;
            end
            apply_config(lo, hi, pick_gain(), pick_gain(), pick_gain(),
                         {1'($urandom_range(0, 1)), pick_limit()});
            target = 16'($urandom_range(0, 4095));
            for (int n = 0; n < PHASE_TICKS; n++) begin
                // hold the setpoint for runs so the integrator winds up
                if ($urandom_range(0, 9) == 0) begin
                    if ($urandom_range(0, 3) == 0) target = 16'($urandom_range(0, 65535));
                    else target = 16'($urandom_range(0, 4095));
                end
                if ($urandom_range(0, 2) == 0) begin
                    fbi = $urandom_range(0, 4095);
                end else begin
                    t = (target > 16'd4095) ? 4095 : int'(target);
                    fbi = t + int'($urandom_range(0, 80)) - 40;
                    if (fbi < 0) fbi = 0;
                    if (fbi > 4095) fbi = 4095;
                end
                send_tick(target, SAMPLE_BITS'(fbi));
                if (n == PHASE_TICKS / 2) wait_drained();
            end
        end
        wait_drained();
    endtask

    always @(posedge aclk) begin : sink_ready_gen
        int left;
        left = stall_left;
        if (left != 0) left--;
        else if (sink_stalls_on && $urandom_range(0, 9) == 0) left = $urandom_range(1, 14);
        stall_left <= left;
        m_tready   <= (left == 0);
    end

    always @(posedge aclk) begin : result_check
        tick_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[OUT_W-1:0];
            if (tick_expect_q.size() == 0) begin
                $error("result transaction with no tick outstanding");
                mismatch_count++;
            end else begin
                want = tick_expect_q.pop_front();
                if (got.cmd !== want.cmd) begin
                    $error("drive_command: expected %0d, got %0d", want.cmd, got.cmd);
                    mismatch_count++;
                end
                if (got.tgt !== want.tgt) begin
                    $error("clamped_target: expected %0d, got %0d", want.tgt, got.tgt);
                    mismatch_count++;
                end
                if (got.err !== want.err) begin
                    $error("position_error: expected %0d, got %0d", want.err, got.err);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $error("no transaction for %0d cycles", QUIET_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_target_clamp();
        test_unused_index();
        test_max_gains();
        test_lowered_limit();
        test_random_loop();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[pid_position_controller.f]
+incdir+sv
sv/ppc_pkg.sv
sv/pid_position_controller.sv
sv/ppc_checker.sv
test/tb_pid_position_controller.sv
